FILE: rtl/core/spatio_temporal_denoise_macros.svh
// assertion macros shared by the denoiser checker
`ifndef SPATIO_TEMPORAL_DENOISE_MACROS_SVH
`define SPATIO_TEMPORAL_DENOISE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define STDN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define STDN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/stdn_pkg.sv
// shared types, constants and conversion functions of the spatio-temporal denoiser
package stdn_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_INDEX_BITS = 4;

  // output queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_PIXEL         = 2'd0,
    CMD_LOAD_SPATIAL  = 2'd1,
    CMD_LOAD_TEMPORAL = 2'd2
  } stdn_cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_BITS = 2'd0,
    REG_SPATIAL_EN  = 2'd1,
    REG_TEMPORAL_EN = 2'd2
  } stdn_reg_t;

  // pixel payload moving through the spatial stages
  typedef struct packed {
    logic        row_start;
    logic        first_row;
    logic [15:0] load;
    logic [15:0] hist;
  } stdn_pix_t;

  // coefficient table write request
  typedef struct packed {
    logic        spatial_we;
    logic        temporal_we;
    logic [12:0] index;
    logic [15:0] value;
  } stdn_tw_t;

  // spatial result handed to the temporal stage
  typedef struct packed {
    logic        valid;
    logic [15:0] val;
    logic [15:0] hist;
  } stdn_tmp_t;

  // one result transaction
  typedef struct packed {
    logic [9:0]  pixel_out;
    logic [15:0] new_history;
    logic        pixel_valid;
  } stdn_res_t;

  // widen a sample to 16 bits with half-step rounding, depth clamped to 8..10
  function automatic logic [15:0] to_internal(input logic [9:0] smp, input logic [3:0] bits);
    logic [15:0] r;
    priority if (bits <= 4'd8) begin
      r = {smp[7:0], 8'd127};
    end else if (bits == 4'd9) begin
      r = {smp[8:0], 7'd63};
    end else begin
      r = {smp, 6'd31};
    end
    return r;
  endfunction

  // shift a 16-bit value back to sample depth, depth clamped to 8..10
  function automatic logic [9:0] from_internal(input logic [15:0] t, input logic [3:0] bits);
    logic [9:0] r;
    priority if (bits <= 4'd8) begin
      r = {2'b00, t[15:8]};
    end else if (bits == 4'd9) begin
      r = {1'b0, t[15:7]};
    end else begin
      r = t[15:6];
    end
    return r;
  endfunction

  // prev - cur offset by 65536; the table address is its top bits
  function automatic logic [16:0] lp_diff(input logic [15:0] prev, input logic [15:0] cur);
    return {1'b1, prev} - {1'b0, cur};
  endfunction

endpackage

FILE: rtl/core/spatio_temporal_denoise.sv
// spatio-temporal denoiser top: input stage, config registers, table loads, output credit
// path: an accepted pixel is registered through stages 1 to 4 and the output queue before out_*
// throughput: one transaction per cycle while in_tready holds; the horizontal recursion closes
//   each cycle through one spatial table read; a load waits while a pixel is in stages 1 and 2
// reset: rst_n is synchronous; it clears stage valids, queue, column and horizontal value
//   and loads config defaults; line store and tables keep their contents
module spatio_temporal_denoise #(
  parameter int MAX_WIDTH  = stdn_pkg::DEF_MAX_WIDTH,
  parameter int INDEX_BITS = stdn_pkg::DEF_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample[9:0], history[25:10], table_index[38:26], table_value[54:39], zero pad
  input  logic [stdn_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0], row_start[2], first_row[3]
  input  logic [stdn_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_out[9:0], new_history[25:10], zero pad
  output logic [stdn_pkg::OUT_DATA_W-1:0] out_tdata,
  // pixel_valid[0]
  output logic [stdn_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [stdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stdn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [3:0] sample_bits_r;
  logic       spatial_en_r, temporal_en_r;

  logic [1:0]  in_cmd;
  logic        is_pix, is_load, in_acc, pix_acc, out_acc, tbl_busy, sp_busy;
  logic [15:0] in_load;

  logic [COL_W-1:0] col_r, col0, col_nxt;
  logic [COL_W:0]   col_inc;

  logic                v1_r;
  stdn_pkg::stdn_pix_t p1_r;
  logic [COL_W-1:0]    col1_r;

  logic [stdn_pkg::FIFO_CNT_W-1:0] pend_r, pend_nxt;

  stdn_pkg::stdn_tw_t  tw;
  stdn_pkg::stdn_tmp_t tmp;
  stdn_pkg::stdn_res_t res4, res_out;
  logic                res4_valid;

  // input decode
  assign in_cmd  = in_tuser[1:0];
  assign is_pix  = (in_cmd == stdn_pkg::CMD_PIXEL);
  assign is_load = (in_cmd == stdn_pkg::CMD_LOAD_SPATIAL) ||
                   (in_cmd == stdn_pkg::CMD_LOAD_TEMPORAL);
  assign in_load = stdn_pkg::to_internal(in_tdata[9:0], sample_bits_r);

  // credit for the output queue, plus the table load interlock
  assign tbl_busy  = v1_r || sp_busy;
  assign in_tready = (pend_r < stdn_pkg::FIFO_CNT_W'(stdn_pkg::FIFO_DEPTH)) &&
                     !(is_load && tbl_busy);
  assign in_acc    = in_tvalid && in_tready;
  assign pix_acc   = in_acc && is_pix;
  assign out_acc   = out_tvalid && out_tready;
  assign pend_nxt  = pend_r + stdn_pkg::FIFO_CNT_W'(pix_acc) -
                     stdn_pkg::FIFO_CNT_W'(out_acc);

  // column counter with wrap at the line width
  assign col0    = in_tuser[2] ? '0 : col_r;
  assign col_inc = {1'b0, col0} + (COL_W + 1)'(1);
  assign col_nxt = (col_inc >= (COL_W + 1)'(MAX_WIDTH)) ? '0 : col_inc[COL_W-1:0];

  // table writes take effect at the accepting edge
  always_comb begin
    tw.spatial_we  = in_acc && (in_cmd == stdn_pkg::CMD_LOAD_SPATIAL);
    tw.temporal_we = in_acc && (in_cmd == stdn_pkg::CMD_LOAD_TEMPORAL);
    tw.index       = in_tdata[38:26];
    tw.value       = in_tdata[54:39];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bits_r <= 4'd8;
      spatial_en_r  <= 1'b0;
      temporal_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        stdn_pkg::REG_SAMPLE_BITS: sample_bits_r <= cfg_wdata;
        stdn_pkg::REG_SPATIAL_EN:  spatial_en_r  <= cfg_wdata[0];
        stdn_pkg::REG_TEMPORAL_EN: temporal_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // control state: stage 1 valid, column, outstanding results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      col_r  <= '0;
      pend_r <= '0;
    end else begin
      v1_r   <= pix_acc;
      pend_r <= pend_nxt;
      if (pix_acc) begin
        col_r <= col_nxt;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    p1_r.row_start <= in_tuser[2];
    p1_r.first_row <= in_tuser[3];
    p1_r.load      <= in_load;
    p1_r.hist      <= in_tdata[25:10];
    col1_r         <= col0;
  end

  stdn_spatial #(
    .MAX_WIDTH  (MAX_WIDTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_spatial (
    .clk        (clk),
    .rst_n      (rst_n),
    .spatial_en (spatial_en_r),
    .v1         (v1_r),
    .pix1       (p1_r),
    .col1       (col1_r),
    .tw         (tw),
    .busy       (sp_busy),
    .tmp        (tmp)
  );

  stdn_temporal #(
    .INDEX_BITS (INDEX_BITS)
  ) u_temporal (
    .clk         (clk),
    .rst_n       (rst_n),
    .temporal_en (temporal_en_r),
    .sample_bits (sample_bits_r),
    .tmp         (tmp),
    .tw          (tw),
    .res_valid   (res4_valid),
    .res         (res4)
  );

  stdn_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res4_valid),
    .push_res  (res4),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res_out)
  );

  // result packing
  assign out_tdata = {6'd0, res_out.new_history, res_out.pixel_out};
  assign out_tuser = res_out.pixel_valid;

endmodule

FILE: rtl/core/stdn_spatial.sv
// horizontal and vertical passes: spatial table, line store and the running horizontal value
module stdn_spatial #(
  parameter int MAX_WIDTH  = stdn_pkg::DEF_MAX_WIDTH,
  parameter int INDEX_BITS = stdn_pkg::DEF_INDEX_BITS,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                spatial_en,
  input  logic                v1,
  input  stdn_pkg::stdn_pix_t pix1,
  input  logic [COL_W-1:0]    col1,
  input  stdn_pkg::stdn_tw_t  tw,
  output logic                busy,
  output stdn_pkg::stdn_tmp_t tmp
);

  localparam int TAB_AW    = 9 + INDEX_BITS;
  localparam int TAB_DEPTH = 1 << TAB_AW;

  logic [15:0] stab_mem [TAB_DEPTH];
  logic [15:0] line_mem [MAX_WIDTH];

  logic                v2_r, v3_r;
  stdn_pkg::stdn_pix_t p2_r, p3_r;
  logic [COL_W-1:0]    col2_r, col3_r;
  logic [15:0]         rda_r, rdb_r, rdl_r;
  logic                fwdo_r;
  logic [15:0]         h3_r, h_r, lw_r;

  logic [15:0]       h2, hprev, hsrc, v3, line2;
  logic [16:0]       diff_a, diff_b;
  logic [TAB_AW-1:0] addr_a, addr_b;
  logic              wr3;

  // horizontal value of the pixel in stage 2
  assign h2 = (p2_r.first_row || !p2_r.row_start) ? p2_r.load + rda_r : p2_r.load;

  // horizontal recursion: newest horizontal value, bypassed from stage 2
  assign hprev  = (v2_r && spatial_en) ? h2 : h_r;
  assign hsrc   = pix1.row_start ? pix1.load : hprev;
  assign diff_a = stdn_pkg::lp_diff(hsrc, pix1.load);
  assign addr_a = diff_a[16 -: TAB_AW];

  // vertical result in stage 3, written back to the line store
  assign v3  = p3_r.first_row ? h3_r : h3_r + rdb_r;
  assign wr3 = v3_r && spatial_en;

  // line store forwarding: stage 3 write first, then the write that raced the read
  assign line2  = (wr3 && (col3_r == col2_r)) ? v3 : (fwdo_r ? lw_r : rdl_r);
  assign diff_b = stdn_pkg::lp_diff(line2, h2);
  assign addr_b = diff_b[16 -: TAB_AW];

  // spatial table: one write, two registered reads (read before write)
  always_ff @(posedge clk) begin
    if (tw.spatial_we) begin
      stab_mem[TAB_AW'(tw.index)] <= tw.value;
    end
    rda_r <= stab_mem[addr_a];
    rdb_r <= stab_mem[addr_b];
  end

  // line store: write from stage 3, registered read for stage 1
  always_ff @(posedge clk) begin
    if (wr3) begin
      line_mem[col3_r] <= v3;
    end
    rdl_r <= line_mem[col1];
  end

  // stage valids and horizontal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      h_r  <= 16'd0;
    end else begin
      v2_r <= v1;
      v3_r <= v2_r;
      if (v2_r && spatial_en) begin
        h_r <= h2;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    p2_r   <= pix1;
    col2_r <= col1;
    fwdo_r <= wr3 && (col3_r == col1);
    p3_r   <= p2_r;
    col3_r <= col2_r;
    h3_r   <= h2;
    if (wr3) begin
      lw_r <= v3;
    end
  end

  // hand-off to the temporal stage
  always_comb begin
    tmp.valid = v3_r;
    tmp.val   = spatial_en ? v3 : p3_r.load;
    tmp.hist  = p3_r.hist;
  end

  assign busy = v2_r;

endmodule

FILE: rtl/core/stdn_temporal.sv
// temporal pass against the history word and result formatting
module stdn_temporal #(
  parameter int INDEX_BITS = stdn_pkg::DEF_INDEX_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                temporal_en,
  input  logic [3:0]          sample_bits,
  input  stdn_pkg::stdn_tmp_t tmp,
  input  stdn_pkg::stdn_tw_t  tw,
  output logic                res_valid,
  output stdn_pkg::stdn_res_t res
);

  localparam int TAB_AW    = 9 + INDEX_BITS;
  localparam int TAB_DEPTH = 1 << TAB_AW;

  logic [15:0] ttab_mem [TAB_DEPTH];

  logic              v4_r;
  logic [15:0]       val4_r, rdt_r;
  logic [16:0]       diff_t;
  logic [TAB_AW-1:0] addr_t;
  logic [15:0]       t4;

  assign diff_t = stdn_pkg::lp_diff(tmp.hist, tmp.val);
  assign addr_t = diff_t[16 -: TAB_AW];

  // temporal table: one write, one registered read (read before write)
  always_ff @(posedge clk) begin
    if (tw.temporal_we) begin
      ttab_mem[TAB_AW'(tw.index)] <= tw.value;
    end
    rdt_r <= ttab_mem[addr_t];
  end

  // stage 4 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= tmp.valid;
    end
  end

  always_ff @(posedge clk) begin
    val4_r <= tmp.val;
  end

  assign t4 = val4_r + rdt_r;

  // filtered output, or history only when priming
  always_comb begin
    if (temporal_en) begin
      res.pixel_out   = stdn_pkg::from_internal(t4, sample_bits);
      res.new_history = t4;
      res.pixel_valid = 1'b1;
    end else begin
      res.pixel_out   = 10'd0;
      res.new_history = val4_r;
      res.pixel_valid = 1'b0;
    end
  end

  assign res_valid = v4_r;

endmodule

FILE: rtl/core/stdn_out_fifo.sv
// output queue that decouples the pipeline from the result channel
module stdn_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stdn_pkg::stdn_res_t push_res,
  output logic                out_valid,
  input  logic                out_ready,
  output stdn_pkg::stdn_res_t out_res
);

  stdn_pkg::stdn_res_t fifo_mem [stdn_pkg::FIFO_DEPTH];

  logic [stdn_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [stdn_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = fifo_mem[rd_ptr_r];
  assign cnt_nxt   = cnt_r + stdn_pkg::FIFO_CNT_W'(push) - stdn_pkg::FIFO_CNT_W'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + stdn_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + stdn_pkg::FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/stdn_checker.sv
// port-level assertions for the denoiser and their bind to the top level
`include "spatio_temporal_denoise_macros.svh"

module stdn_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [stdn_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stdn_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [stdn_pkg::OUT_USER_W-1:0] out_tuser
);

  // a stalled result keeps its contents
  `STDN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // results without a valid pixel carry a zero pixel field
  `STDN_ASSERT_NOW(a_prime_zero, out_tvalid && !out_tuser[0], out_tdata[9:0] == 10'd0, "nonzero pixel in prime result")

  // a table load never directly follows a pixel, the tables are still being read
  `STDN_ASSERT_NEXT(a_load_interlock, in_tvalid && in_tready && in_tuser[1:0] == stdn_pkg::CMD_PIXEL, !(in_tvalid && in_tready && (in_tuser[1:0] == stdn_pkg::CMD_LOAD_SPATIAL || in_tuser[1:0] == stdn_pkg::CMD_LOAD_TEMPORAL)), "table load accepted behind a pixel")

  // nothing is offered right after reset
  `STDN_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_tvalid, "result offered right after reset")

endmodule

bind spatio_temporal_denoise stdn_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
